/* sv/adts_stream_scanner_macros.svh */
// Assertion macros used by adts_chk, the ADTS stream scanner checker.
// Depends on nothing; included by files that assert.
`ifndef ADTS_STREAM_SCANNER_MACROS_SVH
`define ADTS_STREAM_SCANNER_MACROS_SVH

// Check cons in the same cycle as ante.
`define ADTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define ADTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/adts_pkg.sv */
// Shared types, constants and the sample-rate table of the ADTS stream scanner.
// Depends on nothing; used by the divider, datapath, controller, top level and bench.
package adts_pkg;

  localparam int FRAME_COUNT_BITS_DEF = 24;

  localparam logic [7:0]  SYNC_BYTE0    = 8'hFF;
  localparam logic [7:0]  SYNC_MASK1    = 8'hF6;
  localparam logic [7:0]  SYNC_VAL1     = 8'hF0;
  localparam logic [7:0]  RATE_MASK     = 8'h3C;
  localparam logic [1:0]  LEN_HI_MASK   = 2'h3;
  localparam logic [12:0] MIN_FRAME_LEN = 13'd8;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 20;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam logic [MUL_B_W-1:0] MS_SCALE = 20'd1024000;

  localparam int DIV_W     = 54;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [31:0] NO_RATE_MS = 32'd1000;

  typedef enum logic [2:0] {
    ST_SCAN,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_K,
    ST_WAIT_K,
    ST_DIV_M,
    ST_WAIT_M,
    ST_EMIT
  } state_t;

  typedef enum logic {
    MUL_TOTAL_RATE,
    MUL_FRAMES_SCALE
  } mul_sel_t;

  typedef enum logic {
    DIV_KBPS,
    DIV_MS
  } div_sel_t;

  typedef struct packed {
    logic     take;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_kbps;
    logic     cap_ms;
    logic     load_out;
  } ctrl_cmd_t;

  function automatic logic [16:0] rate_hz(input logic [3:0] idx);
    logic [16:0] r;
    unique case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      4'd12:   r = 17'd7350;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/adts_in_if.sv */
// Byte request channel of the ADTS stream scanner: valid, ready, byte, last_byte.
// Depends on nothing.
interface adts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* sv/adts_out_if.sv */
// Summary request channel of the ADTS stream scanner: valid, ready and the stream summary.
// Depends on nothing.
interface adts_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] frame_count;
  logic [31:0] total_bytes;
  logic [16:0] sample_rate_hz;
  logic [15:0] bitrate_kbps;
  logic [31:0] duration_ms;

  modport source (
    output valid, output frame_count, output total_bytes, output sample_rate_hz,
    output bitrate_kbps, output duration_ms, input ready
  );
  modport sink (
    input valid, input frame_count, input total_bytes, input sample_rate_hz,
    input bitrate_kbps, input duration_ms, output ready
  );
endinterface

/* sv/adts_div.sv */
// Shared restoring divider of the ADTS stream scanner, one quotient bit per cycle.
// Depends on adts_pkg for the operand width.
module adts_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [adts_pkg::DIV_W-1:0] dividend,
  input  logic [adts_pkg::DIV_W-1:0] divisor,
  output logic [adts_pkg::DIV_W-1:0] quotient,
  output logic                       done
);

  logic [adts_pkg::DIV_W-1:0]     rem_r, rem_nxt;
  logic [adts_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [adts_pkg::DIV_W-1:0]     dsr_r;
  logic [adts_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [adts_pkg::DIV_W:0]       trial;
  logic [adts_pkg::DIV_W:0]       diff;
  logic                           ge;

  assign trial = {rem_r, quo_r[adts_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = adts_pkg::DIV_CNT_W'(adts_pkg::DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[adts_pkg::DIV_W-1:0] : trial[adts_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[adts_pkg::DIV_W-2:0], ge};
      cnt_nxt = cnt_r - adts_pkg::DIV_CNT_W'(1);
      if (cnt_r == adts_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

/* sv/adts_datapath.sv */
// Datapath of the ADTS stream scanner: header capture, frame walk, totals, multiplier,
// divider operands and the result register. Depends on adts_pkg and adts_div.
module adts_datapath #(
  parameter int FRAME_COUNT_BITS = adts_pkg::FRAME_COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  adts_pkg::ctrl_cmd_t   cmd,
  input  logic [7:0]            in_data_byte,
  output logic                  div_done,
  output logic [23:0]           out_frame_count,
  output logic [31:0]           out_total_bytes,
  output logic [16:0]           out_sample_rate_hz,
  output logic [15:0]           out_bitrate_kbps,
  output logic [31:0]           out_duration_ms
);

  logic [12:0]                 offset_r, offset_nxt;
  logic [7:0]                  hdr_r [0:5];
  logic [7:0]                  hdr_nxt [0:5];
  logic [12:0]                 cur_len_r, cur_len_nxt;
  logic [FRAME_COUNT_BITS-1:0] frames_r, frames_nxt;
  logic [31:0]                 total_r, total_nxt;
  logic [3:0]                  rate_idx_r, rate_idx_nxt;
  logic                        stopped_r, stopped_nxt;
  logic                        taken_r, taken_nxt;

  logic [12:0] hdr_len;
  logic [7:0]  sync_bits;
  logic [7:0]  rate_bits;
  logic        sync_ok;
  logic        hdr_fail;
  logic [12:0] len_eff;
  logic [32:0] total_sum;

  logic [16:0] rate_cur;
  logic [31:0] frames_ext;
  logic        frames_zero;

  logic [adts_pkg::MUL_A_W-1:0] mul_a;
  logic [adts_pkg::MUL_B_W-1:0] mul_b;
  logic [adts_pkg::PROD_W-1:0]  prod;
  logic [adts_pkg::PROD_W-1:0]  prod_a_r;
  logic [adts_pkg::PROD_W-1:0]  prod_b_r;

  logic [adts_pkg::DIV_W-1:0] dvd;
  logic [adts_pkg::DIV_W-1:0] dsr;
  logic [adts_pkg::DIV_W-1:0] quo;
  logic [15:0]                kbps_r;
  logic [31:0]                ms_r;

  assign hdr_len   = {hdr_r[3][1:0] & adts_pkg::LEN_HI_MASK, hdr_r[4], hdr_r[5][7:5]};
  assign sync_bits = hdr_r[1] & adts_pkg::SYNC_MASK1;
  assign sync_ok   = (hdr_r[0] == adts_pkg::SYNC_BYTE0) && (sync_bits == adts_pkg::SYNC_VAL1);
  assign rate_bits = hdr_r[2] & adts_pkg::RATE_MASK;
  assign total_sum = {1'b0, total_r} + 33'(hdr_len);

  always_comb begin
    offset_nxt   = offset_r;
    hdr_nxt      = hdr_r;
    cur_len_nxt  = cur_len_r;
    frames_nxt   = frames_r;
    total_nxt    = total_r;
    rate_idx_nxt = rate_idx_r;
    stopped_nxt  = stopped_r;
    taken_nxt    = taken_r;
    hdr_fail     = 1'b0;
    len_eff      = cur_len_r;
    if (cmd.load_out) begin
      offset_nxt   = '0;
      cur_len_nxt  = '0;
      frames_nxt   = '0;
      total_nxt    = '0;
      rate_idx_nxt = '0;
      stopped_nxt  = 1'b0;
      taken_nxt    = 1'b0;
    end else if (cmd.take && !stopped_r) begin
      if (offset_r < 13'd6) begin
        hdr_nxt[offset_r[2:0]] = in_data_byte;
      end
      if (offset_r == 13'd7) begin
        if (!sync_ok || (hdr_len < adts_pkg::MIN_FRAME_LEN)) begin
          stopped_nxt = 1'b1;
          hdr_fail    = 1'b1;
        end else begin
          if (!taken_r) begin
            rate_idx_nxt = rate_bits[5:2];
            taken_nxt    = 1'b1;
          end
          cur_len_nxt = hdr_len;
          len_eff     = hdr_len;
          total_nxt   = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
        end
      end
      if (!hdr_fail) begin
        if ((offset_r >= 13'd7) && (({1'b0, offset_r} + 14'd1) >= {1'b0, len_eff})) begin
          if (frames_r != '1) begin
            frames_nxt = frames_r + FRAME_COUNT_BITS'(1);
          end
          offset_nxt = '0;
        end else begin
          offset_nxt = offset_r + 13'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= '0;
      cur_len_r  <= '0;
      frames_r   <= '0;
      total_r    <= '0;
      rate_idx_r <= '0;
      stopped_r  <= 1'b0;
      taken_r    <= 1'b0;
    end else begin
      offset_r   <= offset_nxt;
      cur_len_r  <= cur_len_nxt;
      frames_r   <= frames_nxt;
      total_r    <= total_nxt;
      rate_idx_r <= rate_idx_nxt;
      stopped_r  <= stopped_nxt;
      taken_r    <= taken_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

  assign rate_cur    = taken_r ? adts_pkg::rate_hz(rate_idx_r) : 17'd0;
  assign frames_ext  = 32'(frames_r);
  assign frames_zero = (frames_r == '0);

  assign mul_a = (cmd.mul_sel == adts_pkg::MUL_FRAMES_SCALE) ? frames_ext : total_r;
  assign mul_b = (cmd.mul_sel == adts_pkg::MUL_FRAMES_SCALE) ? adts_pkg::MS_SCALE
                                                             : adts_pkg::MUL_B_W'(rate_cur);
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en && (cmd.mul_sel == adts_pkg::MUL_TOTAL_RATE)) begin
      prod_a_r <= prod;
    end
    if (cmd.mul_en && (cmd.mul_sel == adts_pkg::MUL_FRAMES_SCALE)) begin
      prod_b_r <= prod;
    end
  end

  // kbps: (16*total*rate + frames*scale) / (2*frames*scale)
  // ms:   (2*frames*scale + rate) / (2*rate)
  always_comb begin
    if (cmd.div_sel == adts_pkg::DIV_MS) begin
      dvd = (adts_pkg::DIV_W'(prod_b_r) << 1) + adts_pkg::DIV_W'(rate_cur);
      dsr = adts_pkg::DIV_W'(rate_cur) << 1;
    end else begin
      dvd = (adts_pkg::DIV_W'(prod_a_r) << 4) + adts_pkg::DIV_W'(prod_b_r);
      dsr = adts_pkg::DIV_W'(prod_b_r) << 1;
    end
  end

  adts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .quotient (quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_kbps) begin
      if (frames_zero) begin
        kbps_r <= '0;
      end else begin
        kbps_r <= (|quo[adts_pkg::DIV_W-1:16]) ? 16'hFFFF : quo[15:0];
      end
    end
    if (cmd.cap_ms) begin
      if (rate_cur == 17'd0) begin
        ms_r <= adts_pkg::NO_RATE_MS;
      end else begin
        ms_r <= (|quo[adts_pkg::DIV_W-1:32]) ? 32'hFFFF_FFFF : quo[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_frame_count    <= (frames_ext > 32'h00FF_FFFF) ? 24'hFF_FFFF : frames_ext[23:0];
      out_total_bytes    <= total_r;
      out_sample_rate_hz <= rate_cur;
      out_bitrate_kbps   <= kbps_r;
      out_duration_ms    <= ms_r;
    end
  end

endmodule

/* sv/adts_ctrl.sv */
// Controller of the ADTS stream scanner: request handshakes and the summary sequence.
// Depends on adts_pkg for the state and command types.
module adts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_byte,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  logic                div_done,
  output adts_pkg::ctrl_cmd_t cmd
);

  adts_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_sel   = adts_pkg::MUL_TOTAL_RATE;
    cmd.div_sel   = adts_pkg::DIV_KBPS;
    unique case (state_r)
      adts_pkg::ST_SCAN: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && in_last_byte) begin
          state_nxt = adts_pkg::ST_MUL_A;
        end
      end
      adts_pkg::ST_MUL_A: begin
        cmd.mul_en = 1'b1;
        state_nxt  = adts_pkg::ST_MUL_B;
      end
      adts_pkg::ST_MUL_B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = adts_pkg::MUL_FRAMES_SCALE;
        state_nxt   = adts_pkg::ST_DIV_K;
      end
      adts_pkg::ST_DIV_K: begin
        cmd.div_start = 1'b1;
        state_nxt     = adts_pkg::ST_WAIT_K;
      end
      adts_pkg::ST_WAIT_K: begin
        if (div_done) begin
          cmd.cap_kbps = 1'b1;
          state_nxt    = adts_pkg::ST_DIV_M;
        end
      end
      adts_pkg::ST_DIV_M: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = adts_pkg::DIV_MS;
        state_nxt     = adts_pkg::ST_WAIT_M;
      end
      adts_pkg::ST_WAIT_M: begin
        cmd.div_sel = adts_pkg::DIV_MS;
        if (div_done) begin
          cmd.cap_ms = 1'b1;
          state_nxt  = adts_pkg::ST_EMIT;
        end
      end
      adts_pkg::ST_EMIT: begin
        cmd.div_sel = adts_pkg::DIV_MS;
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = adts_pkg::ST_SCAN;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adts_pkg::ST_SCAN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/adts_stream_scanner.sv */
// Top level of the ADTS stream scanner: controller, datapath and request channels.
// Depends on adts_pkg, adts_in_if, adts_out_if, adts_ctrl and adts_datapath.
//
// The scanner takes an ADTS byte stream one byte per cycle and walks it frame by
// frame; in_ch.ready stays high while bytes stream in. The byte flagged last_byte
// starts the summary: two products on one shared 32x20 multiplier, then two
// quotients on a shared restoring divider that makes one bit per cycle over 54 bits.
// Input ready is low after the final byte while the controller runs the multiply,
// divide and emit states, and also while the previous summary is held in the output
// register. A held summary does not stop the next stream's bytes from being taken.
module adts_stream_scanner #(
  parameter int FRAME_COUNT_BITS = adts_pkg::FRAME_COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  adts_in_if.sink     in_ch,
  adts_out_if.source  out_ch
);

  adts_pkg::ctrl_cmd_t cmd;
  logic                div_done;

  adts_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_last_byte (in_ch.last_byte),
    .in_ready     (in_ch.ready),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .div_done     (div_done),
    .cmd          (cmd)
  );

  adts_datapath #(
    .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_data_byte       (in_ch.data_byte),
    .div_done           (div_done),
    .out_frame_count    (out_ch.frame_count),
    .out_total_bytes    (out_ch.total_bytes),
    .out_sample_rate_hz (out_ch.sample_rate_hz),
    .out_bitrate_kbps   (out_ch.bitrate_kbps),
    .out_duration_ms    (out_ch.duration_ms)
  );

endmodule

/* sv/adts_chk.sv */
// Port-level assertions of the ADTS stream scanner and the bind that attaches them.
// Depends on adts_stream_scanner_macros.svh and the top level adts_stream_scanner.
`include "adts_stream_scanner_macros.svh"

module adts_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_frame_count,
  input logic [31:0] out_total_bytes,
  input logic [16:0] out_sample_rate_hz,
  input logic [15:0] out_bitrate_kbps,
  input logic [31:0] out_duration_ms
);

  `ADTS_ASSERT_NEXT(a_last_closes_input, clk, rst_n, in_valid && in_ready && in_last_byte, !in_ready, "request taken right after the final byte")
  `ADTS_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_frame_count) && $stable(out_total_bytes) && $stable(out_sample_rate_hz) && $stable(out_bitrate_kbps) && $stable(out_duration_ms), "stalled summary changed")
  `ADTS_ASSERT_NOW(a_no_frames_no_rate, clk, rst_n, out_valid && (out_frame_count == 24'd0), out_bitrate_kbps == 16'd0, "bitrate without frames")
  `ADTS_ASSERT_NOW(a_zero_rate_ms, clk, rst_n, out_valid && (out_sample_rate_hz == 17'd0), out_duration_ms == 32'd1000, "duration wrong for zero rate")

endmodule

bind adts_stream_scanner adts_chk u_adts_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_last_byte       (in_ch.last_byte),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_frame_count    (out_ch.frame_count),
  .out_total_bytes    (out_ch.total_bytes),
  .out_sample_rate_hz (out_ch.sample_rate_hz),
  .out_bitrate_kbps   (out_ch.bitrate_kbps),
  .out_duration_ms    (out_ch.duration_ms)
);

/* bench/adts_scan_checker.sv */
// Scoreboard for the ADTS stream scanner: tracks the byte stream, predicts each summary.
// Compares every accepted summary field by field against the oldest prediction.
// Depends on adts_pkg, adts_in_if and adts_out_if.
module adts_scan_checker (
  input  logic clk,
  input  logic rst_n,
  adts_in_if   in_ch,
  adts_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [23:0] frame_count;
    logic [31:0] total_bytes;
    logic [16:0] sample_rate_hz;
    logic [15:0] bitrate_kbps;
    logic [31:0] duration_ms;
  } summary_t;

  localparam logic [23:0] FRAMES_MAX     = 24'hFF_FFFF;
  localparam logic [31:0] BYTES_MAX      = 32'hFFFF_FFFF;
  localparam logic [63:0] KBPS_MAX       = 64'd65535;
  localparam logic [63:0] FRAME_MS_SCALE = 64'd1024000;

  logic [16:0] rate_table [16] = '{
    17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000, 17'd24000, 17'd22050,
    17'd16000, 17'd12000, 17'd11025, 17'd8000, 17'd7350, 17'd0, 17'd0, 17'd0
  };

  logic [12:0] pos;
  logic [7:0]  hdr [6];
  logic [12:0] frame_len;
  logic [23:0] frames;
  logic [31:0] byte_sum;
  logic [3:0]  rate_idx;
  logic        halted;
  logic        rate_locked;
  summary_t    summary_q [$];
  int          errors = 0;

  task automatic clear_scan();
    pos = '0;
    for (int i = 0; i < 6; i++) hdr[i] = '0;
    frame_len   = '0;
    frames      = '0;
    byte_sum    = '0;
    rate_idx    = '0;
    halted      = 1'b0;
    rate_locked = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b);
    logic [12:0] len;
    logic [7:0]  idx_bits;
    logic        sync;
    int unsigned p;
    if (halted) return;
    p = pos;
    if (p < 6) hdr[p] = b;
    if (p == 7) begin
      len  = {hdr[3][1:0] & adts_pkg::LEN_HI_MASK, hdr[4], hdr[5][7:5]};
      sync = (hdr[0] == adts_pkg::SYNC_BYTE0) &&
             ((hdr[1] & adts_pkg::SYNC_MASK1) == adts_pkg::SYNC_VAL1);
      if (!sync || len < adts_pkg::MIN_FRAME_LEN) begin
        halted = 1'b1;
        return;
      end
      if (!rate_locked) begin
        idx_bits    = (hdr[2] & adts_pkg::RATE_MASK) >> 2;
        rate_idx    = idx_bits[3:0];
        rate_locked = 1'b1;
      end
      frame_len = len;
      byte_sum  = (byte_sum > BYTES_MAX - len) ? BYTES_MAX : byte_sum + len;
    end
    if (p >= 7 && p + 1 >= frame_len) begin
      if (frames < FRAMES_MAX) frames = frames + 1'b1;
      pos = '0;
    end else begin
      pos = pos + 1'b1;
    end
  endtask

  function automatic summary_t summarize();
    summary_t    s;
    logic [16:0] rate;
    logic [63:0] num, den, kbps, ms;
    rate = rate_locked ? rate_table[rate_idx] : '0;
    kbps = '0;
    if (frames != 0) begin
      num  = 64'd8 * byte_sum * rate;
      den  = FRAME_MS_SCALE * frames;
      kbps = (64'd2 * num + den) / (64'd2 * den);
      if (kbps > KBPS_MAX) kbps = KBPS_MAX;
    end
    if (rate == 0) begin
      ms = 64'd1000;
    end else begin
      num = FRAME_MS_SCALE * frames;
      ms  = (64'd2 * num + rate) / (64'd2 * rate);
      if (ms > BYTES_MAX) ms = BYTES_MAX;
    end
    s.frame_count    = frames;
    s.total_bytes    = byte_sum;
    s.sample_rate_hz = rate;
    s.bitrate_kbps   = kbps[15:0];
    s.duration_ms    = ms[31:0];
    return s;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    summary_t want;
    if (!rst_n) begin
      clear_scan();
      summary_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (summary_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected summary, expected none, got frames %0d bytes %0d",
                   $time, out_ch.frame_count, out_ch.total_bytes);
        end else begin
          want = summary_q.pop_front();
          check_field("frame_count", want.frame_count, out_ch.frame_count);
          check_field("total_bytes", want.total_bytes, out_ch.total_bytes);
          check_field("sample_rate_hz", want.sample_rate_hz, out_ch.sample_rate_hz);
          check_field("bitrate_kbps", want.bitrate_kbps, out_ch.bitrate_kbps);
          check_field("duration_ms", want.duration_ms, out_ch.duration_ms);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        scan_byte(in_ch.data_byte);
        if (in_ch.last_byte) begin
          summary_q.push_back(summarize());
          clear_scan();
        end
      end
    end
    fail_count <= errors;
    pending    <= summary_q.size();
  end

endmodule

/* bench/tb_adts_stream_scanner.sv */
// Top of the ADTS stream scanner bench: clock, reset, byte-stream and summary-side drivers.
// Builds directed and random ADTS streams; adts_scan_checker predicts and compares.
// Depends on adts_pkg, adts_in_if, adts_out_if, adts_stream_scanner and adts_scan_checker.
module tb_adts_stream_scanner;

  localparam int CYCLE_LIMIT = 500000;

  typedef enum int {
    HDR_SYNC_OK,
    HDR_BAD_FIRST,
    HDR_BAD_SECOND
  } hdr_kind_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   bytes_sent = 0;
  bit   directed_done = 1'b0;
  logic [7:0] stream_q [$];

  adts_in_if  in_ch ();
  adts_out_if out_ch ();

  adts_stream_scanner dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  adts_scan_checker scan_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  task automatic add_header(input logic [12:0] len, input logic [3:0] idx,
                            input hdr_kind_t kind);
    logic [31:0] r, r2;
    logic [7:0]  b0, b1;
    r  = $urandom;
    r2 = $urandom;
    b0 = adts_pkg::SYNC_BYTE0;
    b1 = adts_pkg::SYNC_VAL1 | {4'b0000, r[3], 2'b00, r[0]};
    case (kind)
      HDR_BAD_FIRST: begin
        r2 = $urandom_range(0, 254);
        b0 = r2[7:0];
      end
      HDR_BAD_SECOND: begin
        b1 = r[23:16];
        if ((b1 & adts_pkg::SYNC_MASK1) == adts_pkg::SYNC_VAL1) b1[1] = 1'b1;
      end
      default: ;
    endcase
    stream_q.push_back(b0);
    stream_q.push_back(b1);
    stream_q.push_back({r[31:30], idx, r[29:28]});
    stream_q.push_back({r[27:22], len[12:11]});
    stream_q.push_back(len[10:3]);
    stream_q.push_back({len[2:0], r[21:17]});
    stream_q.push_back(r2[15:8]);
    stream_q.push_back(r2[23:16]);
  endtask

  task automatic add_body(input int n);
    logic [31:0] r;
    for (int i = 0; i < n; i++) begin
      r = $urandom;
      stream_q.push_back(r[7:0]);
    end
  endtask

  task automatic send_stream();
    int gap;
    bit calm;
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < stream_q.size(); i++) begin
      in_ch.valid     <= 1'b1;
      in_ch.data_byte <= stream_q[i];
      in_ch.last_byte <= (i == stream_q.size() - 1);
      do @(posedge clk); while (!in_ch.ready);
      bytes_sent++;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    stream_q.delete();
  endtask

  task automatic add_good_frame();
    logic [31:0] len_w, r;
    len_w = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(8, 16);
    r     = $urandom;
    add_header(len_w[12:0], r[3:0], HDR_SYNC_OK);
    add_body(len_w - 8);
  endtask

  initial begin : summary_side
    int  on_len;
    int  gap;
    bit  held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (directed_done && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (1500) @(posedge clk);
      end
      on_len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
      out_ch.ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int          streams;
    int          nfr;
    int          ending;
    logic [31:0] len_w, r;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one minimal frame at the top rate
    add_header(13'd8, 4'd0, HDR_SYNC_OK);
    send_stream();
    // truncated frame of the largest length, lowest listed rate
    add_header(13'h1FFF, 4'd12, HDR_SYNC_OK);
    send_stream();
    // short tail
    stream_q.push_back(8'hFF);
    stream_q.push_back(8'hF1);
    stream_q.push_back(8'h00);
    send_stream();
    // sync loss through a length below the minimum
    add_header(13'd5, 4'd3, HDR_SYNC_OK);
    send_stream();
    directed_done = 1'b1;

    streams = 0;
    while (streams < 12 || bytes_sent < 500) begin
      if (streams == 6) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      nfr    = $urandom_range(0, 2);
      ending = $urandom_range(0, 9);
      for (int f = 0; f < nfr; f++) add_good_frame();
      r = $urandom;
      case (ending)
        4, 5: add_body($urandom_range(1, 7));
        6: begin
          len_w = $urandom_range(21, 8191);
          add_header(len_w[12:0], r[3:0], HDR_SYNC_OK);
          add_body($urandom_range(0, 12));
        end
        7: begin
          len_w = $urandom_range(8, 16);
          case (r[5:4])
            2'd0:    add_header(len_w[12:0], r[3:0], HDR_BAD_FIRST);
            2'd1:    add_header(len_w[12:0], r[3:0], HDR_BAD_SECOND);
            default: begin
              len_w = $urandom_range(0, 7);
              add_header(len_w[12:0], r[3:0], HDR_SYNC_OK);
            end
          endcase
          add_body($urandom_range(0, 5));
        end
        8: add_body($urandom_range(1, 20));
        default: if (nfr == 0) add_good_frame();
      endcase
      send_stream();
      streams++;
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule
